### sv/mst_bottleneck_k_clusters_core_macros.svh
// Assertion helpers shared by the checker
`ifndef MST_BOTTLENECK_K_CLUSTERS_CORE_MACROS_SVH
`define MST_BOTTLENECK_K_CLUSTERS_CORE_MACROS_SVH

// same-cycle implication
`define MBK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MBK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/mbk_pkg.sv
`timescale 1ns / 1ps
package mbk_pkg;
  localparam int MAX_POINTS = 512;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CFG_W      = 10;
  localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int COORD_W    = 16;
  localparam int MAG_W      = COORD_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int SQ_W       = PROD_W + 1;
  localparam int DIST_W     = SQ_W + 1;
  localparam int LEN_W      = 25;
  localparam int RAD_W      = 2 * LEN_W;
  localparam int REM_W      = LEN_W + 3;
  localparam int SQRT_CNT_W = $clog2(LEN_W + 1);
  // joined points carry this value in the best-distance store
  localparam logic [DIST_W-1:0] DIST_JOINED = '1;
endpackage

### sv/mst_bottleneck_k_clusters_core.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     start / busy          in_x_coord, in_y_coord, in_last_point
// result    out_valid (strobe)    out_squared_length, out_length_fixed, out_overflow
// config    cfg_valid / cfg_ready cfg_data (channel count)
//
// A point without the last mark is stored while busy stays low.
// The last point starts the tree search: n-1 scans of n points through the
// shared distance unit, then a rank search over the n-1 edge lengths, then
// 25 root steps. One read port per store sets the pace. Reset is synchronous;
// the store needs no clearing. Results are a one-cycle strobe; the receiver
// cannot stall.
module mst_bottleneck_k_clusters_core import mbk_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic                      in_last_point,
  output logic                      out_valid,
  output logic [SQ_W-1:0]           out_squared_length,
  output logic [LEN_W-1:0]          out_length_fixed,
  output logic                      out_overflow,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_W-1:0]          cfg_data
);
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_PREP  = 10'b0000000010,
    ST_LOAD  = 10'b0000000100,
    ST_PASS  = 10'b0000001000,
    ST_PEND  = 10'b0000010000,
    ST_SRD   = 10'b0000100000,
    ST_SLAT  = 10'b0001000000,
    ST_SSCAN = 10'b0010000000,
    ST_SCHK  = 10'b0100000000,
    ST_SQRT  = 10'b1000000000
  } state_t;

  state_t state_r;
  logic [CNT_W-1:0] total_r, nm1, lt_r, le_r, k_r;
  logic             drop_r;
  logic [CFG_W-1:0] chan_r;
  logic             accept;

  // stores
  logic signed [COORD_W-1:0] x_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] y_mem [MAX_POINTS];
  logic [DIST_W-1:0]         best_mem [MAX_POINTS];
  logic [DIST_W-1:0]         acc_mem [MAX_POINTS];
  logic signed [COORD_W-1:0] rx_r, ry_r, x2_r, y2_r, x3_r, y3_r;
  logic [DIST_W-1:0]         rb_r, b2_r, b3_r, acc_rd_r;

  // tree search
  logic [IDX_W-1:0] rd_idx_r, idx1_r, idx2_r, idx3_r, last_idx, pass_r, pick_r, min_idx_r;
  logic             scan_r, v1_r, v2_r, v3_r, first_r, found_r;
  logic signed [COORD_W-1:0] px_r, py_r, min_x_r, min_y_r;
  logic [DIST_W-1:0] minv_r, d34, nb;
  logic [SQ_W-1:0]   dist_sq;
  logic              joined3, is_pick, best_we, cand;
  logic [DIST_W-1:0] best_wd;

  // rank search
  logic [IDX_W-1:0] a_r, b_r, acc_ra, mlast;
  logic             sv1_r, sl1_r;
  logic [DIST_W-1:0] va_r;
  logic [SQ_W-1:0]   sq_r;

  // prep arithmetic
  logic [CMP_W-1:0] n_ext, c_ext, t_ext, tt_ext, nm1_ext;

  // root unit
  logic             sqrt_go_r, sqrt_done;
  logic [LEN_W-1:0] root;

  // result registers
  logic             out_valid_r, out_overflow_r;
  logic [SQ_W-1:0]  out_sq_r;
  logic [LEN_W-1:0] out_len_r;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign nm1       = total_r - 1'b1;
  assign last_idx  = nm1[IDX_W-1:0];
  assign mlast     = IDX_W'(total_r - CNT_W'(2));
  assign acc_ra    = (state_r == ST_SSCAN) ? b_r : a_r;

  // edge count target
  always_comb begin
    n_ext   = CMP_W'(total_r);
    c_ext   = CMP_W'(chan_r);
    nm1_ext = CMP_W'(nm1);
    t_ext   = (n_ext > c_ext) ? n_ext - c_ext : '0;
    tt_ext  = (t_ext > nm1_ext) ? nm1_ext : t_ext;
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && total_r != CNT_W'(MAX_POINTS)) begin
      x_mem[total_r[IDX_W-1:0]] <= in_x_coord;
      y_mem[total_r[IDX_W-1:0]] <= in_y_coord;
    end
    rx_r <= x_mem[rd_idx_r];
    ry_r <= y_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (best_we) best_mem[idx3_r] <= best_wd;
    rb_r <= best_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PEND) acc_mem[pass_r] <= minv_r;
    acc_rd_r <= acc_mem[acc_ra];
  end

  // shared distance unit, registered magnitudes then squares between stage 1 and stage 3
  mbk_dist u_dist (
    .clk     (clk),
    .a_x     (px_r),
    .a_y     (py_r),
    .b_x     (rx_r),
    .b_y     (ry_r),
    .dist_sq (dist_sq)
  );

  // stage 3: relax and track the nearest outside point
  always_comb begin
    d34     = {1'b0, dist_sq};
    joined3 = !first_r && (b3_r == DIST_JOINED);
    is_pick = (idx3_r == pick_r);
    nb      = (first_r || d34 < b3_r) ? d34 : b3_r;
    best_we = v3_r && (is_pick || !joined3);
    best_wd = is_pick ? DIST_JOINED : nb;
    cand    = v3_r && !is_pick && !joined3 && (!found_r || nb < minv_r);
  end

  // scan pipeline payload
  always_ff @(posedge clk) begin
    idx1_r <= rd_idx_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    x2_r   <= rx_r;
    y2_r   <= ry_r;
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    b2_r   <= rb_r;
    b3_r   <= b2_r;
    if (cand) begin
      minv_r    <= nb;
      min_idx_r <= idx3_r;
      min_x_r   <= x3_r;
      min_y_r   <= y3_r;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      total_r   <= '0;
      drop_r    <= 1'b0;
      chan_r    <= CFG_W'(1);
      rd_idx_r  <= '0;
      scan_r    <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      sv1_r     <= 1'b0;
      found_r   <= 1'b0;
      sqrt_go_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sqrt_go_r   <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r  <= scan_r && (state_r == ST_PASS);
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      sv1_r <= scan_r && (state_r == ST_SSCAN);
      sl1_r <= (b_r == mlast);
      if (cand) found_r <= 1'b1;
      if (cfg_valid && cfg_ready) chan_r <= cfg_data;

      case (state_r)
        ST_IDLE: begin
          rd_idx_r <= '0;
          if (accept) begin
            if (total_r == CNT_W'(MAX_POINTS)) drop_r <= 1'b1;
            else total_r <= total_r + 1'b1;
            if (in_last_point) state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (total_r < CNT_W'(2) || t_ext == '0) begin
            sq_r      <= '0;
            sqrt_go_r <= 1'b1;
            state_r   <= ST_SQRT;
          end else begin
            k_r     <= CNT_W'(tt_ext - CMP_W'(1));
            pick_r  <= '0;
            pass_r  <= '0;
            first_r <= 1'b1;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          px_r    <= rx_r;
          py_r    <= ry_r;
          found_r <= 1'b0;
          scan_r  <= 1'b1;
          state_r <= ST_PASS;
        end
        ST_PASS: begin
          if (scan_r) begin
            if (rd_idx_r == last_idx) scan_r <= 1'b0;
            else rd_idx_r <= rd_idx_r + 1'b1;
          end
          if (v3_r && idx3_r == last_idx) state_r <= ST_PEND;
        end
        ST_PEND: begin
          rd_idx_r <= '0;
          if (CNT_W'(pass_r) + CNT_W'(1) == nm1) begin
            a_r     <= '0;
            lt_r    <= '0;
            le_r    <= '0;
            state_r <= ST_SRD;
          end else begin
            pass_r  <= pass_r + 1'b1;
            pick_r  <= min_idx_r;
            px_r    <= min_x_r;
            py_r    <= min_y_r;
            first_r <= 1'b0;
            found_r <= 1'b0;
            scan_r  <= 1'b1;
            state_r <= ST_PASS;
          end
        end
        ST_SRD: begin
          state_r <= ST_SLAT;
        end
        ST_SLAT: begin
          va_r    <= acc_rd_r;
          b_r     <= '0;
          scan_r  <= 1'b1;
          state_r <= ST_SSCAN;
        end
        ST_SSCAN: begin
          if (scan_r) begin
            if (b_r == mlast) scan_r <= 1'b0;
            else b_r <= b_r + 1'b1;
          end
          if (sv1_r) begin
            if (acc_rd_r < va_r) lt_r <= lt_r + 1'b1;
            if (acc_rd_r <= va_r) le_r <= le_r + 1'b1;
            if (sl1_r) state_r <= ST_SCHK;
          end
        end
        ST_SCHK: begin
          if (lt_r <= k_r && k_r < le_r) begin
            sq_r      <= va_r[SQ_W-1:0];
            sqrt_go_r <= 1'b1;
            state_r   <= ST_SQRT;
          end else begin
            a_r     <= a_r + 1'b1;
            lt_r    <= '0;
            le_r    <= '0;
            state_r <= ST_SRD;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            out_valid_r    <= 1'b1;
            out_sq_r       <= sq_r;
            out_len_r      <= root;
            out_overflow_r <= drop_r;
            total_r        <= '0;
            drop_r         <= 1'b0;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  mbk_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sqrt_go_r),
    .sq    (sq_r),
    .done  (sqrt_done),
    .root  (root)
  );

  assign out_valid          = out_valid_r;
  assign out_squared_length = out_sq_r;
  assign out_length_fixed   = out_len_r;
  assign out_overflow       = out_overflow_r;
endmodule

### sv/mbk_dist.sv
`timescale 1ns / 1ps
module mbk_dist import mbk_pkg::*; (
  input  logic                      clk,
  input  logic signed [COORD_W-1:0] a_x,
  input  logic signed [COORD_W-1:0] a_y,
  input  logic signed [COORD_W-1:0] b_x,
  input  logic signed [COORD_W-1:0] b_y,
  output logic        [SQ_W-1:0]    dist_sq
);
  logic signed [COORD_W:0] dx, dy, ndx, ndy;
  logic [MAG_W-1:0]  adx_r, ady_r;
  logic [PROD_W-1:0] sqx_r, sqy_r;

  // absolute differences
  always_comb begin
    dx  = {a_x[COORD_W-1], a_x} - {b_x[COORD_W-1], b_x};
    dy  = {a_y[COORD_W-1], a_y} - {b_y[COORD_W-1], b_y};
    ndx = -dx;
    ndy = -dy;
  end

  // stage 1: magnitudes, stage 2: squares
  always_ff @(posedge clk) begin
    adx_r <= dx[COORD_W] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
    ady_r <= dy[COORD_W] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
    sqx_r <= adx_r * adx_r;
    sqy_r <= ady_r * ady_r;
  end

  assign dist_sq = {1'b0, sqx_r} + {1'b0, sqy_r};
endmodule

### sv/mbk_sqrt.sv
`timescale 1ns / 1ps
module mbk_sqrt import mbk_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            go,
  input  logic [SQ_W-1:0] sq,
  output logic            done,
  output logic [LEN_W-1:0] root
);
  logic [RAD_W-1:0]      rad_r;
  logic [REM_W-1:0]      rem_r, rem_s, trial;
  logic [LEN_W-1:0]      root_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic                  run_r, done_r;

  // one result bit per step: shift in two radicand bits, trial subtract
  always_comb begin
    rem_s = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= SQRT_CNT_W'(LEN_W - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      rad_r  <= {{(RAD_W - SQ_W - 16){1'b0}}, sq, 16'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem_r  <= rem_s - trial;
        root_r <= {root_r[LEN_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_s;
        root_r <= {root_r[LEN_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

### sv/mbk_checker.sv
`timescale 1ns / 1ps
`include "mst_bottleneck_k_clusters_core_macros.svh"
module mbk_checker import mbk_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             in_last_point,
  input logic             out_valid,
  input logic [SQ_W-1:0]  out_squared_length,
  input logic [LEN_W-1:0] out_length_fixed
);
  // a result is a single-cycle strobe
  `MBK_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  // the last point starts work
  `MBK_ASSERT_NEXT(a_last_busy, start && !busy && in_last_point, busy, "last point did not start work")
  // a result is shown only once the block is free again
  `MBK_ASSERT_NOW(a_out_idle, out_valid, !busy, "result shown while busy")
  // zero length has zero root
  `MBK_ASSERT_NOW(a_zero_root, out_valid && out_squared_length == '0, out_length_fixed == '0,
    "nonzero root of zero length")
endmodule

bind mst_bottleneck_k_clusters_core mbk_checker u_mbk_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_last_point      (in_last_point),
  .out_valid          (out_valid),
  .out_squared_length (out_squared_length),
  .out_length_fixed   (out_length_fixed)
);
